FILE: hdl/mxp_pkg.sv
package mxp_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int WIDTH     = 31;
  localparam int NODES     = 1 + MAX_ITEMS * WIDTH;

  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int LVL_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int ENTRY_W = 2 * NODE_W;

  typedef struct packed {
    logic [WIDTH-1:0] value;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [WIDTH-1:0] max_pair_xor;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic accept;
    logic ins_step;
    logic leaf;
    logic srch_begin;
    logic srch_step;
    logic cmp;
    logic clear;
    logic init_root;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic lvl_zero;
    logic scan_done;
    logic last_q;
  } dp_status_t;

endpackage

FILE: hdl/mxp_ctrl.sv
module mxp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                last,
  input  mxp_pkg::dp_status_t status,
  output mxp_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_LEAF  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_SWALK = 3'd5;
  localparam logic [2:0] S_CMP   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.init_root = 1'b1;
        state_next    = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (!status.full) begin
            state_next = S_INS;
          end else if (last) begin
            state_next = S_FETCH;
          end
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (status.lvl_zero) begin
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        cmd.leaf   = 1'b1;
        state_next = status.last_q ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        if (status.scan_done) begin
          state_next = S_OUT;
        end else begin
          cmd.srch_begin = 1'b1;
          state_next     = S_SWALK;
        end
      end
      S_SWALK: begin
        cmd.srch_step = 1'b1;
        if (status.lvl_zero) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = S_FETCH;
      end
      S_OUT: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("result strobe not followed by idle");

  a_ins_to_leaf: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && status.lvl_zero) |=> (state == S_LEAF))
    else $error("insert walk did not finish with leaf step");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

FILE: hdl/mxp_datapath.sv
module mxp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mxp_pkg::dp_cmd_t    cmd,
  input  mxp_pkg::item_t      item,
  output mxp_pkg::dp_status_t status,
  output mxp_pkg::result_t    result
);

  localparam int NW = mxp_pkg::NODE_W;
  localparam int W  = mxp_pkg::WIDTH;

  // node entry is {child1, child0}; child index 0 means no child
  logic [mxp_pkg::ENTRY_W-1:0] node_mem [mxp_pkg::NODES];
  logic [W-1:0]                elem_mem [mxp_pkg::MAX_ITEMS];

  logic [mxp_pkg::ENTRY_W-1:0] rdata;
  logic [W-1:0]                erdata;
  logic [NW-1:0]               raddr;
  logic                        wen;
  logic [NW-1:0]               waddr;
  logic [mxp_pkg::ENTRY_W-1:0] wdata;

  logic [W-1:0]                value_q;
  logic                        last_q;
  logic [NW-1:0]               cur_node;
  logic [mxp_pkg::LVL_W-1:0]   lvl;
  logic                        alloc;
  logic                        alive;
  logic [W-1:0]                acc;
  logic [W-1:0]                best;
  logic [NW-1:0]               node_count;
  logic [mxp_pkg::CNT_W-1:0]   item_count;
  logic [mxp_pkg::CNT_W-1:0]   idx;
  logic                        overflow_seen;

  logic [NW-1:0] child0;
  logic [NW-1:0] child1;
  logic          ins_bit;
  logic [NW-1:0] ins_child;
  logic          make_new;
  logic          want;
  logic [NW-1:0] want_child;
  logic [NW-1:0] other_child;
  logic          take_want;
  logic          full;

  assign child0 = rdata[NW-1:0];
  assign child1 = rdata[2*NW-1:NW];
  assign full   = (item_count == mxp_pkg::CNT_W'(mxp_pkg::MAX_ITEMS));

  assign ins_bit   = value_q[lvl];
  assign ins_child = ins_bit ? child1 : child0;
  assign make_new  = alloc || (ins_child == '0);

  assign want        = ~erdata[lvl];
  assign want_child  = want ? child1 : child0;
  assign other_child = want ? child0 : child1;
  assign take_want   = alive && (want_child != '0);

  always_comb begin
    raddr = '0;
    wen   = 1'b0;
    waddr = cur_node;
    wdata = '0;
    if (cmd.ins_step) begin
      if (make_new) begin
        wen = 1'b1;
        // fresh nodes below the first allocation have no other child
        if (ins_bit) begin
          wdata = {node_count, alloc ? {NW{1'b0}} : child0};
        end else begin
          wdata = {alloc ? {NW{1'b0}} : child1, node_count};
        end
      end else begin
        raddr = ins_child;
      end
    end else if (cmd.leaf) begin
      wen = alloc;
    end else if (cmd.srch_step) begin
      if (take_want) begin
        raddr = want_child;
      end else if (alive) begin
        raddr = other_child;
      end
    end else if (cmd.clear || cmd.init_root) begin
      wen   = 1'b1;
      waddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      node_mem[waddr] <= wdata;
    end
    rdata <= node_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !full) begin
      elem_mem[item_count[mxp_pkg::IDX_W-1:0]] <= item.value;
    end
    erdata <= elem_mem[idx[mxp_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= NW'(1);
      item_count    <= '0;
      idx           <= '0;
      overflow_seen <= 1'b0;
      best          <= '0;
      alloc         <= 1'b0;
      alive         <= 1'b1;
      last_q        <= 1'b0;
    end else begin
      if (cmd.accept) begin
        value_q <= item.value;
        last_q  <= item.last;
        if (!full) begin
          item_count <= item_count + mxp_pkg::CNT_W'(1);
          cur_node   <= '0;
          lvl        <= mxp_pkg::LVL_W'(W - 1);
          alloc      <= 1'b0;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.ins_step) begin
        lvl <= lvl - mxp_pkg::LVL_W'(1);
        if (make_new) begin
          cur_node   <= node_count;
          node_count <= node_count + NW'(1);
          alloc      <= 1'b1;
        end else begin
          cur_node <= ins_child;
        end
      end
      if (cmd.srch_begin) begin
        lvl   <= mxp_pkg::LVL_W'(W - 1);
        alive <= 1'b1;
        acc   <= '0;
      end
      if (cmd.srch_step) begin
        lvl <= lvl - mxp_pkg::LVL_W'(1);
        acc <= {acc[W-2:0], take_want};
        if (!take_want && alive && other_child == '0) begin
          alive <= 1'b0;
        end
      end
      if (cmd.cmp) begin
        if (acc > best) begin
          best <= acc;
        end
        idx <= idx + mxp_pkg::CNT_W'(1);
      end
      if (cmd.clear) begin
        node_count    <= NW'(1);
        item_count    <= '0;
        idx           <= '0;
        overflow_seen <= 1'b0;
        best          <= '0;
      end
    end
  end

  assign status.full      = full;
  assign status.lvl_zero  = (lvl == '0);
  assign status.scan_done = (idx == item_count);
  assign status.last_q    = last_q;

  assign result.max_pair_xor = best;
  assign result.overflow     = overflow_seen;

  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= NW'(mxp_pkg::NODES))
    else $error("node table overrun");

  a_item_bound: assert property (@(posedge clk) disable iff (rst)
    (item_count <= mxp_pkg::CNT_W'(mxp_pkg::MAX_ITEMS)) && (idx <= item_count))
    else $error("item or scan count out of range");

  a_walk_alive: assert property (@(posedge clk) disable iff (rst)
    cmd.srch_step |-> alive)
    else $error("search walk left the trie");

  a_alloc_sticky: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_step && alloc) |=> alloc)
    else $error("allocation mode dropped mid insert");

endmodule

FILE: hdl/max_xor_pair_trie.sv
// Greatest XOR of any two values in a set. Pulse start with an item while busy
// is low; each accepted value is stored and inserted into a binary trie, one
// trie level per cycle through the node memory, so after an item is taken in,
// busy stays high while it walks down the levels and its leaf step follows. An
// item that arrives when MAX_ITEMS values are already held is dropped and
// flags overflow. The item with last set starts the search: every stored
// value walks the trie, one level per cycle, with a fetch step before its walk
// and a compare step after it. The result appears with done for exactly one
// cycle and must be taken then; the block cannot be stalled by the receiver.
// After the result the set is cleared and the next item may follow. Out of
// reset busy stays high for one cycle while the trie root is cleared.
module max_xor_pair_trie (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mxp_pkg::item_t   item,
  output logic             busy,
  output logic             done,
  output mxp_pkg::result_t result
);

  mxp_pkg::dp_cmd_t    cmd;
  mxp_pkg::dp_status_t status;

  mxp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (item.last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mxp_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule
